@@ rtl/swf_pkg.sv @@
// shared types, constants and helpers for the shallow water flux unit
package swf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W        = 63;
  localparam int DIV_STAGES    = PROD_W;
  localparam int FULL_W        = PROD_W + 32;
  localparam int CFG_IDX_W     = 2;

  localparam logic [61:0]        CAP62 = '1;
  localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN48 = -64'sh0000_8000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWEEP   = 2'd0,
    REG_LIMIT   = 2'd1,
    REG_INVERSE = 2'd2,
    REG_HALF_G  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        dry;
    logic        last;
    logic        hneg;
    logic        pneg;
    logic [31:0] qd;
    logic [61:0] gmul;
    logic [61:0] omul;
  } side_t;

  function automatic logic [61:0] cap62(input logic [FULL_W-1:0] v);
    logic [61:0] r;
    r = (|v[FULL_W-1:62]) ? CAP62 : v[61:0];
    return r;
  endfunction

  function automatic logic [47:0] sat48(input logic signed [63:0] v);
    logic [47:0] r;
    if (v > MAX48) begin
      r = MAX48[47:0];
    end else if (v < MIN48) begin
      r = MIN48[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/shallow_water_flux.sv @@
// shallow water flux unit: one grid cell in, one flux triple out, pipelined
// throughput: one request per cycle, set by the 63-stage one-bit-per-stage divider
// busy is high only during reset and the first cycle after it
// synchronous active-low reset loads config register defaults and clears pipeline valid bits
// results are strobed for one cycle and cannot be held off by the receiver
module shallow_water_flux #(
  parameter int FRACTION_BITS = swf_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           in_depth,
  input  logic signed [31:0]           in_momentum_x,
  input  logic signed [31:0]           in_momentum_y,
  input  logic                         in_last_cell,
  output logic                         out_valid,
  output logic signed [47:0]           out_flux_depth,
  output logic signed [47:0]           out_flux_momentum_x,
  output logic signed [47:0]           out_flux_momentum_y,
  output logic                         out_dry_cell,
  output logic                         out_last_out,
  input  logic                         cfg_we,
  input  logic [swf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);
  import swf_pkg::*;

  localparam int SH_WET = 2 * FRACTION_BITS;
  localparam int LATENCY = DIV_STAGES + 5;

  logic        sweep_r;
  logic [15:0] limit_r;
  logic [31:0] inverse_r;
  logic [31:0] half_g_r;
  logic        busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r   <= 1'b0;
      limit_r   <= 16'd1;
      inverse_r <= 32'd8388608;
      half_g_r  <= 32'd321454;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SWEEP:   sweep_r   <= cfg_data[0];
        REG_LIMIT:   limit_r   <= cfg_data[15:0];
        REG_INVERSE: inverse_r <= cfg_data;
        REG_HALF_G:  half_g_r  <= cfg_data;
        default:     sweep_r   <= sweep_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  // stage 0: request capture
  logic               s0_vld_r;
  logic signed [31:0] s0_h_r, s0_q1_r, s0_q2_r;
  logic               s0_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_h_r    <= in_depth;
    s0_q1_r   <= in_momentum_x;
    s0_q2_r   <= in_momentum_y;
    s0_last_r <= in_last_cell;
  end

  // stage 1: products of the cell values
  logic [31:0]        s1_habs_nxt;
  logic               s1_dry_nxt;
  logic signed [31:0] s1_qd_nxt;
  logic signed [63:0] pd_full, po_full;
  logic [63:0]        hsq_full;
  logic [PROD_W-1:0]  s1_po_nxt;

  always_comb begin
    s1_habs_nxt = s0_h_r[31] ? 32'(-s0_h_r) : 32'(s0_h_r);
    s1_dry_nxt  = (s0_h_r == 32'sd0) || (s1_habs_nxt < {16'd0, limit_r});
    s1_qd_nxt   = sweep_r ? s0_q2_r : s0_q1_r;
    pd_full     = s1_qd_nxt * s1_qd_nxt;
    po_full     = s0_q1_r * s0_q2_r;
    hsq_full    = s1_habs_nxt * s1_habs_nxt;
    s1_po_nxt   = po_full[63] ? PROD_W'(-po_full) : po_full[PROD_W-1:0];
  end

  logic              s1_vld_r;
  side_t             s1_sd_r;
  logic [PROD_W-1:0] s1_pd_r, s1_po_r, s1_hsq_r;
  logic [31:0]       s1_habs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sd_r.dry  <= s1_dry_nxt;
    s1_sd_r.last <= s0_last_r;
    s1_sd_r.hneg <= s0_h_r[31];
    s1_sd_r.pneg <= po_full[63];
    s1_sd_r.qd   <= s1_qd_nxt;
    s1_sd_r.gmul <= '0;
    s1_sd_r.omul <= '0;
    s1_pd_r      <= pd_full[PROD_W-1:0];
    s1_po_r      <= s1_po_nxt;
    s1_hsq_r     <= hsq_full[PROD_W-1:0];
    s1_habs_r    <= s1_habs_nxt;
  end

  // stage 2: partial products against the scale factors
  logic [PROD_W-1:0] mul_a;
  logic [31:0]       mul_f;

  always_comb begin
    mul_a = s1_sd_r.dry ? s1_pd_r : s1_hsq_r;
    mul_f = s1_sd_r.dry ? inverse_r : half_g_r;
  end

  logic              s2_vld_r;
  side_t             s2_sd_r;
  logic [PROD_W-1:0] s2_pd_r, s2_po_r;
  logic [31:0]       s2_habs_r;
  logic [63:0]       s2_gl_r, s2_ol_r;
  logic [62:0]       s2_gh_r, s2_oh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sd_r   <= s1_sd_r;
    s2_pd_r   <= s1_pd_r;
    s2_po_r   <= s1_po_r;
    s2_habs_r <= s1_habs_r;
    s2_gl_r   <= mul_a[31:0] * mul_f;
    s2_gh_r   <= mul_a[PROD_W-1:32] * mul_f;
    s2_ol_r   <= s1_po_r[31:0] * inverse_r;
    s2_oh_r   <= s1_po_r[PROD_W-1:32] * inverse_r;
  end

  // stage 3: sum partial products, scale and cap
  logic [FULL_W-1:0] g_full, o_full, g_sh;
  side_t             s3_sd_nxt;

  always_comb begin
    g_full = FULL_W'({s2_gh_r, 32'd0}) + FULL_W'(s2_gl_r);
    o_full = FULL_W'({s2_oh_r, 32'd0}) + FULL_W'(s2_ol_r);
    g_sh   = s2_sd_r.dry ? (g_full >> FRACTION_BITS) : (g_full >> SH_WET);
    s3_sd_nxt      = s2_sd_r;
    s3_sd_nxt.gmul = cap62(g_sh);
    s3_sd_nxt.omul = cap62(o_full >> FRACTION_BITS);
  end

  // divider chain, one quotient bit per stage
  logic              dv_vld_r [0:DIV_STAGES];
  side_t             dv_sd_r  [0:DIV_STAGES];
  logic [PROD_W-1:0] dv_wd_r  [0:DIV_STAGES];
  logic [PROD_W-1:0] dv_wo_r  [0:DIV_STAGES];
  logic [31:0]       dv_rd_r  [0:DIV_STAGES];
  logic [31:0]       dv_ro_r  [0:DIV_STAGES];
  logic [31:0]       dv_d_r   [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_sd_r[0] <= s3_sd_nxt;
    dv_wd_r[0] <= s2_pd_r;
    dv_wo_r[0] <= s2_po_r;
    dv_rd_r[0] <= '0;
    dv_ro_r[0] <= '0;
    dv_d_r[0]  <= s2_habs_r;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [32:0] td, tof;
    logic        ged, geo;

    always_comb begin
      td  = {dv_rd_r[k], dv_wd_r[k][PROD_W-1]};
      tof = {dv_ro_r[k], dv_wo_r[k][PROD_W-1]};
      ged = td >= {1'b0, dv_d_r[k]};
      geo = tof >= {1'b0, dv_d_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_sd_r[k+1] <= dv_sd_r[k];
      dv_d_r[k+1]  <= dv_d_r[k];
      dv_rd_r[k+1] <= ged ? 32'(td - {1'b0, dv_d_r[k]}) : td[31:0];
      dv_ro_r[k+1] <= geo ? 32'(tof - {1'b0, dv_d_r[k]}) : tof[31:0];
      dv_wd_r[k+1] <= {dv_wd_r[k][PROD_W-2:0], ged};
      dv_wo_r[k+1] <= {dv_wo_r[k][PROD_W-2:0], geo};
    end
  end

  // final stage: signs, gravity, saturation
  side_t              fs;
  logic [62:0]        diag_mag, off_mag;
  logic               diag_neg, off_neg;
  logic signed [63:0] diag_val, off_val;
  logic [61:0]        grav;
  logic [47:0]        fx_nxt, fy_nxt, fdiag, foff;

  always_comb begin
    fs       = dv_sd_r[DIV_STAGES];
    diag_mag = fs.dry ? {1'b0, fs.gmul} : dv_wd_r[DIV_STAGES];
    off_mag  = fs.dry ? {1'b0, fs.omul} : dv_wo_r[DIV_STAGES];
    diag_neg = !fs.dry && fs.hneg;
    off_neg  = fs.dry ? fs.pneg : (fs.pneg ^ fs.hneg);
    grav     = fs.dry ? '0 : fs.gmul;
    diag_val = (diag_neg ? -$signed({1'b0, diag_mag}) : $signed({1'b0, diag_mag}))
               + $signed({2'b00, grav});
    off_val  = off_neg ? -$signed({1'b0, off_mag}) : $signed({1'b0, off_mag});
    fdiag    = sat48(diag_val);
    foff     = sat48(off_val);
    fx_nxt   = sweep_r ? foff : fdiag;
    fy_nxt   = sweep_r ? fdiag : foff;
  end

  logic        out_valid_r;
  logic [47:0] fd_r, fx_r, fy_r;
  logic        dry_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    fd_r   <= {{16{fs.qd[31]}}, fs.qd};
    fx_r   <= fx_nxt;
    fy_r   <= fy_nxt;
    dry_r  <= fs.dry;
    last_r <= fs.last;
  end

  assign out_valid           = out_valid_r;
  assign out_flux_depth      = fd_r;
  assign out_flux_momentum_x = fx_r;
  assign out_flux_momentum_y = fy_r;
  assign out_dry_cell        = dry_r;
  assign out_last_out        = last_r;

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request without result at fixed latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[DIV_STAGES] && !dv_sd_r[DIV_STAGES].dry) |->
      (dv_rd_r[DIV_STAGES] < dv_d_r[DIV_STAGES] &&
       dv_ro_r[DIV_STAGES] < dv_d_r[DIV_STAGES]))
    else $error("divider remainder out of range");
`endif

endmodule
